@@ rtl/lswr_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lswr_pkg
// Shared types, sizes and codes for the line slot window reader.
// ---------------------------------------------------------------------------
package lswr_pkg;

  // Slot geometry.
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_BYTES = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LEN_W      = $clog2(SLOT_BYTES);
  localparam int ADDR_W     = SLOT_W + LEN_W;
  localparam int TEXT_DEPTH = SLOT_COUNT * (2 ** LEN_W);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int SEQ_W      = 32;

  // Longest line kept in a slot.
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(SLOT_BYTES - 1);

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Slot modes.
  localparam logic [2:0] MODE_FREE    = 3'd0;
  localparam logic [2:0] MODE_FILLING = 3'd1;
  localparam logic [2:0] MODE_CTRL    = 3'd2;
  localparam logic [2:0] MODE_DATA    = 3'd3;
  localparam logic [2:0] MODE_PROC    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_LINE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // Line kinds.
  localparam logic [1:0] LK_NONE = 2'd0;
  localparam logic [1:0] LK_CTRL = 2'd1;
  localparam logic [1:0] LK_DATA = 2'd2;

  // Item kinds and line terminators.
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] line_kind;
    logic [2:0] slot_index;
    logic [7:0] line_char;
    logic [3:0] free_slots;
    logic       last;
  } result_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic       req;
    logic       term;
    logic [7:0] char_byte;
  } work_t;

  // A line whose first byte is one of these is a control line.
  function automatic logic is_control_char(input logic [7:0] c);
    return (c == 8'h7B) || (c == 8'h24) || (c == 8'h3F) || (c == 8'h21) ||
           (c == 8'h7E) || (c == 8'h25) || (c == 8'h48) || (c == 8'h68);
  endfunction

endpackage
`default_nettype wire

@@ rtl/lswr_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lswr_front
// Accepts items, classifies them and queues them for the back part.
// ---------------------------------------------------------------------------
module lswr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire lswr_pkg::item_t item,
  output logic                 work_valid,
  output lswr_pkg::work_t      work,
  input  wire logic            work_pop
);
  import lswr_pkg::*;

  work_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  work_t             classified;

  // The queue takes an item whenever it has room.
  assign item_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push       = item_valid && item_ready;
  assign pop        = work_pop && work_valid;
  assign work_valid = (count != '0);
  assign work       = queue[rd_ptr];

  // Tag requests and line terminators on the way in.
  always_comb begin
    classified.req       = (item.kind == KIND_REQUEST);
    classified.term      = (item.char_byte == CHAR_CR) || (item.char_byte == CHAR_LF);
    classified.char_byte = item.char_byte;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= classified;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/lswr_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lswr_back
// Owns the slots: stores characters, closes lines, serves requests and
// streams the chosen line out through the result register.
// ---------------------------------------------------------------------------
module lswr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            work_valid,
  input  wire lswr_pkg::work_t work,
  output logic                 work_pop,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output lswr_pkg::result_t    result
);
  import lswr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LD   = 3'd4;

  logic [2:0]       state;

  // Per-slot bookkeeping.
  logic [2:0]       slot_mode     [SLOT_COUNT];
  logic [SEQ_W-1:0] slot_sequence [SLOT_COUNT];
  logic [LEN_W-1:0] slot_length   [SLOT_COUNT];
  logic [SEQ_W-1:0] sequence_counter;

  // Line text store.
  logic [7:0]       text_mem [TEXT_DEPTH];
  logic [7:0]       rd_data;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;

  // The filling slot and the processing slot; there is at most one of each.
  logic              fill_valid;
  logic [SLOT_W-1:0] fill_slot;
  logic [7:0]        fill_first;
  logic              proc_valid;
  logic [SLOT_W-1:0] proc_slot;

  // Request scan.
  logic [SLOT_W-1:0] scan_idx;
  logic [CNT_W-1:0]  free_cnt;
  logic              bc_valid;
  logic [SLOT_W-1:0] bc_slot;
  logic [SEQ_W-1:0]  bc_seq;
  logic              bd_valid;
  logic [SLOT_W-1:0] bd_slot;
  logic [SEQ_W-1:0]  bd_seq;

  // Line streaming.
  logic [SLOT_W-1:0] str_slot;
  logic [1:0]        str_kind;
  logic [LEN_W-1:0]  str_len;
  logic [LEN_W-1:0]  str_idx;

  logic              out_free;
  logic              free_any;
  logic [SLOT_W-1:0] free_slot;
  logic [SEQ_W-1:0]  seq_inc;
  logic              str_last;

  assign out_free = !result_valid || result_ready;
  assign work_pop = (state == S_IDLE) && work_valid && out_free;
  assign str_last = (str_idx == str_len - 1'b1);

  // Next sequence number; zero is skipped on wrap.
  assign seq_inc = (sequence_counter + 1'b1 == '0) ? SEQ_W'(1) : sequence_counter + 1'b1;

  // Lowest free slot.
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_mode[i] == MODE_FREE) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Text write for a stored character, read for streaming.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {fill_slot, slot_length[fill_slot]};
    if (work_pop && !work.req && !work.term) begin
      if (fill_valid) begin
        mem_we = (slot_length[fill_slot] != LEN_MAX);
      end else if (free_any) begin
        mem_we    = 1'b1;
        mem_waddr = {free_slot, {LEN_W{1'b0}}};
      end
    end
  end

  assign mem_raddr = {str_slot, str_idx};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= work.char_byte;
    end
    rd_data <= text_mem[mem_raddr];
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result_valid     <= 1'b0;
      fill_valid       <= 1'b0;
      proc_valid       <= 1'b0;
      sequence_counter <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_mode[i]     <= MODE_FREE;
        slot_sequence[i] <= '0;
        slot_length[i]   <= '0;
      end
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (work_pop) begin
            if (work.req) begin
              // Free the processing slot, then scan all slots.
              if (proc_valid) begin
                slot_mode[proc_slot]     <= MODE_FREE;
                slot_sequence[proc_slot] <= '0;
                slot_length[proc_slot]   <= '0;
                proc_valid               <= 1'b0;
              end
              scan_idx <= '0;
              free_cnt <= '0;
              bc_valid <= 1'b0;
              bd_valid <= 1'b0;
              state    <= S_SCAN;
            end else if (fill_valid) begin
              if (work.term) begin
                // Close the line; a blank one, or one led by a null byte, frees its slot.
                fill_valid <= 1'b0;
                if (slot_length[fill_slot] == '0 || fill_first == 8'h00) begin
                  slot_mode[fill_slot]     <= MODE_FREE;
                  slot_sequence[fill_slot] <= '0;
                  slot_length[fill_slot]   <= '0;
                end else begin
                  sequence_counter         <= seq_inc;
                  slot_sequence[fill_slot] <= seq_inc;
                  slot_mode[fill_slot]     <= is_control_char(fill_first) ? MODE_CTRL
                                                                          : MODE_DATA;
                end
              end else if (slot_length[fill_slot] != LEN_MAX) begin
                slot_length[fill_slot] <= slot_length[fill_slot] + 1'b1;
              end
            end else if (!free_any) begin
              // No room for the character.
              result_valid      <= 1'b1;
              result.status     <= ST_REFUSED;
              result.line_kind  <= LK_NONE;
              result.slot_index <= '0;
              result.line_char  <= '0;
              result.free_slots <= '0;
              result.last       <= 1'b1;
            end else if (!work.term) begin
              // Open a new line in the lowest free slot.
              slot_mode[free_slot]   <= MODE_FILLING;
              slot_length[free_slot] <= LEN_W'(1);
              fill_valid             <= 1'b1;
              fill_slot              <= free_slot;
              fill_first             <= work.char_byte;
            end
          end
        end

        S_SCAN: begin
          // One slot a cycle: count free ones, track the oldest lines.
          if (slot_mode[scan_idx] == MODE_FREE) begin
            free_cnt <= free_cnt + 1'b1;
          end
          if (slot_mode[scan_idx] == MODE_CTRL &&
              (!bc_valid || slot_sequence[scan_idx] < bc_seq)) begin
            bc_valid <= 1'b1;
            bc_slot  <= scan_idx;
            bc_seq   <= slot_sequence[scan_idx];
          end
          if (slot_mode[scan_idx] == MODE_DATA &&
              (!bd_valid || slot_sequence[scan_idx] < bd_seq)) begin
            bd_valid <= 1'b1;
            bd_slot  <= scan_idx;
            bd_seq   <= slot_sequence[scan_idx];
          end
          if (scan_idx == SLOT_W'(SLOT_COUNT - 1)) begin
            state <= S_PICK;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        S_PICK: begin
          if (bc_valid || bd_valid) begin
            // Control lines go before data lines.
            if (bc_valid) begin
              slot_mode[bc_slot] <= MODE_PROC;
              proc_slot          <= bc_slot;
              str_slot           <= bc_slot;
              str_kind           <= LK_CTRL;
              str_len            <= slot_length[bc_slot];
            end else begin
              slot_mode[bd_slot] <= MODE_PROC;
              proc_slot          <= bd_slot;
              str_slot           <= bd_slot;
              str_kind           <= LK_DATA;
              str_len            <= slot_length[bd_slot];
            end
            proc_valid <= 1'b1;
            str_idx    <= '0;
            state      <= S_RD;
          end else if (out_free) begin
            result_valid      <= 1'b1;
            result.status     <= ST_EMPTY;
            result.line_kind  <= LK_NONE;
            result.slot_index <= '0;
            result.line_char  <= '0;
            result.free_slots <= 4'(free_cnt);
            result.last       <= 1'b1;
            state             <= S_IDLE;
          end
        end

        S_RD: begin
          // Text read is in flight.
          state <= S_LD;
        end

        S_LD: begin
          if (out_free) begin
            result_valid      <= 1'b1;
            result.status     <= ST_LINE;
            result.line_kind  <= str_kind;
            result.slot_index <= 3'(str_slot);
            result.line_char  <= rd_data;
            result.free_slots <= 4'(free_cnt);
            result.last       <= str_last;
            if (str_last) begin
              state <= S_IDLE;
            end else begin
              str_idx <= str_idx + 1'b1;
              state   <= S_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/line_slot_window_reader.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// line_slot_window_reader
// Gathers received characters into line slots and hands out whole lines.
// ---------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_ready/item) carries either a received
//   character or a request for the next line. The result channel
//   (result_valid/result_ready/result) returns one result for a refused
//   character, one for a request with no line pending, and otherwise one
//   result per character of the returned line, the final one marked last.
//   A four-entry queue sits between the input side and the slot logic, so
//   items are taken while the slot logic is busy or the receiver stalls.
//   A character is handled by the slot logic and shows no result, or
//   a refused result through the result register. A request releases
//   the processing slot, scans the slots (one slot a cycle, with one
//   sequence comparator per line kind) and picks a line; each line
//   character then passes through a read state and a load state, as the
//   read of the text store is registered.
//   A stalled receiver holds the result register and the slot logic waits.
//   Reset frees all slots and clears the sequence counter and the queue;
//   the text store is not cleared.
// ---------------------------------------------------------------------------
module line_slot_window_reader (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire lswr_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output lswr_pkg::result_t      result
);
  import lswr_pkg::*;

  logic  work_valid;
  work_t work;
  logic  work_pop;

  // Input side: accept and classify.
  lswr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .work_valid (work_valid),
    .work       (work),
    .work_pop   (work_pop)
  );

  // Slot logic and result register.
  lswr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .work_valid   (work_valid),
    .work         (work),
    .work_pop     (work_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A line character always names a line kind.
  a_line_has_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_LINE |-> result.line_kind != LK_NONE)
    else $error("line character without line kind");

  // Refused and empty results are single results.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_LINE |-> result.last)
    else $error("status result not marked last");

  // The free count never exceeds the number of slots.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.free_slots <= 4'(SLOT_COUNT))
    else $error("free slot count out of range");

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

@@ tb/line_slot_window_reader_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_slot_window_reader_checker
// Watches both channels of the line slot reader and checks every result.
//
// Each accepted item updates a private copy of the line slots. Requests and
// refused characters queue the results that the slots owe. Each accepted
// result is compared field by field with the oldest owed result. The checker
// counts mismatches and reports the first few, and it tells the top how many
// results are still outstanding.
// ----------------------------------------------------------------------------
module line_slot_window_reader_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic              item_ready,
  input  wire lswr_pkg::item_t   item,
  input  wire logic              result_valid,
  input  wire logic              result_ready,
  input  wire lswr_pkg::result_t result,
  output int                     mismatches,
  output int                     pending,
  output int                     lines_streamed,
  output int                     empty_requests,
  output int                     refusals,
  output int                     results_compared
);
  import lswr_pkg::*;

  // Private copy of the slot state.
  logic [2:0]       mode_of [SLOT_COUNT];
  logic [SEQ_W-1:0] seq_of  [SLOT_COUNT];
  logic [LEN_W-1:0] len_of  [SLOT_COUNT];
  logic [7:0]       text_of [SLOT_COUNT][SLOT_BYTES];
  logic [SEQ_W-1:0] line_number;
  result_t          owed_results [$];

  // A line that starts with one of these characters is a control line.
  function automatic logic is_command_lead(input logic [7:0] c);
    case (c)
      "{", "$", "?", "!", "~", "%", "H", "h": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int first_slot_in(input logic [2:0] m);
    for (int s = 0; s < SLOT_COUNT; s++)
      if (mode_of[s] == m) return s;
    return -1;
  endfunction

  // Lowest sequence number wins; on a tie the lower slot index stays.
  function automatic int oldest_slot_in(input logic [2:0] m);
    int best;
    best = -1;
    for (int s = 0; s < SLOT_COUNT; s++)
      if (mode_of[s] == m && (best < 0 || seq_of[s] < seq_of[best])) best = s;
    return best;
  endfunction

  function automatic void release_slot(input int s);
    mode_of[s] = MODE_FREE;
    seq_of[s]  = '0;
    len_of[s]  = '0;
  endfunction

  // A blank line, or one led by a null byte, is dropped; any other line is
  // numbered, and the counter never hands out zero.
  function automatic void close_line(input int s);
    if (len_of[s] == 0 || text_of[s][0] == 8'h00) begin
      release_slot(s);
    end else begin
      line_number = line_number + 1'b1;
      if (line_number == '0) line_number = 1;
      seq_of[s]  = line_number;
      mode_of[s] = is_command_lead(text_of[s][0]) ? MODE_CTRL : MODE_DATA;
    end
  endfunction

  // Applies one accepted item to the slots and queues the results it owes.
  function automatic void advance_slots(input item_t it);
    int         s;
    int         free_count;
    logic [1:0] kind_of_line;
    logic       term;
    result_t    r;
    term = (it.char_byte == CHAR_CR) || (it.char_byte == CHAR_LF);
    r = '0;
    if (it.kind == KIND_CHAR) begin
      s = first_slot_in(MODE_FILLING);
      if (s < 0) begin
        s = first_slot_in(MODE_FREE);
        if (s < 0) begin
          r.status = ST_REFUSED;
          r.last   = 1'b1;
          owed_results.push_back(r);
          return;
        end
        // A terminator with no line open is a blank line.
        if (term) return;
        mode_of[s] = MODE_FILLING;
        len_of[s]  = '0;
      end
      if (term) begin
        close_line(s);
      end else if (len_of[s] < LEN_MAX) begin
        text_of[s][len_of[s]] = it.char_byte;
        len_of[s] = len_of[s] + 1'b1;
      end
      return;
    end

    // Request: free the line handed out last time, then pick the next one.
    s = first_slot_in(MODE_PROC);
    if (s >= 0) release_slot(s);
    free_count = 0;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (mode_of[i] == MODE_FREE) free_count++;
    r.free_slots = 4'(free_count);
    kind_of_line = LK_CTRL;
    s = oldest_slot_in(MODE_CTRL);
    if (s < 0) begin
      s = oldest_slot_in(MODE_DATA);
      kind_of_line = LK_DATA;
    end
    if (s < 0) begin
      r.status = ST_EMPTY;
      r.last   = 1'b1;
      owed_results.push_back(r);
      return;
    end
    mode_of[s]   = MODE_PROC;
    r.status     = ST_LINE;
    r.line_kind  = kind_of_line;
    r.slot_index = 3'(s);
    for (int i = 0; i < len_of[s]; i++) begin
      r.line_char = text_of[s][i];
      r.last      = (i + 1 == len_of[s]);
      owed_results.push_back(r);
    end
  endfunction

  // Results are compared before the item of the same edge is applied, since
  // a result never belongs to an item accepted at that very edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int s = 0; s < SLOT_COUNT; s++) release_slot(s);
      line_number = '0;
      owed_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        results_compared++;
        if (result.status == ST_EMPTY) empty_requests++;
        if (result.status == ST_REFUSED) refusals++;
        if (result.status == ST_LINE && result.last) lines_streamed++;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: result with nothing owed", $realtime);
            $display("  got    st=%0d kind=%0d slot=%0d char=%02h free=%0d last=%0d",
                     result.status, result.line_kind, result.slot_index,
                     result.line_char, result.free_slots, result.last);
          end
        end else begin
          want = owed_results.pop_front();
          if (result.status !== want.status || result.line_kind !== want.line_kind ||
              result.slot_index !== want.slot_index || result.line_char !== want.line_char ||
              result.free_slots !== want.free_slots || result.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: result %0d differs", $realtime, results_compared);
              $display("  got    st=%0d kind=%0d slot=%0d char=%02h free=%0d last=%0d",
                       result.status, result.line_kind, result.slot_index,
                       result.line_char, result.free_slots, result.last);
              $display("  wanted st=%0d kind=%0d slot=%0d char=%02h free=%0d last=%0d",
                       want.status, want.line_kind, want.slot_index,
                       want.line_char, want.free_slots, want.last);
            end
          end
        end
      end
      if (item_valid && item_ready) advance_slots(item);
    end
    pending = owed_results.size();
  end

endmodule

@@ tb/line_slot_window_reader_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_slot_window_reader_tb
// Stimulus and verdict for the line slot window reader.
//
// A short directed sequence covers an empty request, stray terminators, a
// line led by a null byte, a full set of slots and refused characters. One
// line longer than a slot follows, then random lines, mostly well formed
// with control or data leads, some blank, mixed with requests and stray
// bytes. The sender works in bursts and the receiver stalls on a shifting
// pattern. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module line_slot_window_reader_tb;
  import lswr_pkg::*;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  int mismatches, pending, lines_streamed, empty_requests, refusals, results_compared;

  item_t      char_items [$];
  int         queued_total   = 0;
  int         accepted_total = 0;
  int         request_total  = 0;
  int         gap_left       = 0;
  int         burst_left     = 0;
  logic [9:0] ready_tick     = '0;

  logic [7:0] command_leads [8] = '{"{", "$", "?", "!", "~", "%", "H", "h"};

  line_slot_window_reader i_dut (
    .clk,
    .rst,
    .item_valid,
    .item_ready,
    .item,
    .result_valid,
    .result_ready,
    .result
  );

  line_slot_window_reader_checker i_checker (
    .clk,
    .rst,
    .item_valid,
    .item_ready,
    .item,
    .result_valid,
    .result_ready,
    .result,
    .mismatches,
    .pending,
    .lines_streamed,
    .empty_requests,
    .refusals,
    .results_compared
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus helpers.
  function automatic void queue_item(input logic k, input logic [7:0] c);
    item_t it;
    it.kind      = k;
    it.char_byte = c;
    char_items.push_back(it);
    if (k == KIND_REQUEST) request_total++;
  endfunction

  // The ignored byte of a request is random too.
  function automatic void queue_request();
    queue_item(KIND_REQUEST, 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_CR || c == CHAR_LF);
    return c;
  endfunction

  function automatic logic [7:0] lead_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return command_leads[$urandom_range(0, 7)];
    if (roll < 45) return 8'h00;
    return body_byte();
  endfunction

  // A line of the given length, closed by CR or LF at random.
  function automatic void queue_line(input int length);
    for (int i = 0; i < length; i++)
      queue_item(KIND_CHAR, (i == 0) ? lead_byte() : body_byte());
    queue_item(KIND_CHAR, ($urandom_range(0, 1) == 1) ? CHAR_CR : CHAR_LF);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (item_valid && item_ready) accepted_total <= accepted_total + 1;
      if (!item_valid || item_ready) begin
        if (gap_left > 0) begin
          item_valid <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (char_items.size() > 0) begin
          item_valid <= 1'b1;
          item       <= char_items.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern follows bits 9 to 7 of a free-running tick counter.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      ready_tick   <= '0;
    end else begin
      ready_tick <= ready_tick + 1'b1;
      case (ready_tick[9:7])
        3'd2: result_ready <= (ready_tick[2:0] != 3'd0);
        3'd3: result_ready <= ($urandom_range(0, 1) == 1);
        3'd4: result_ready <= ready_tick[3];
        3'd5: result_ready <= ($urandom_range(0, 4) != 0);
        3'd6: result_ready <= ($urandom_range(0, 4) == 0);
        default: result_ready <= 1'b1;
      endcase
    end
  end

  // Main sequence: build all stimulus, release reset, wait for the drain.
  initial begin
    int roll;
    int length;

    // Directed part. Nothing pending, then terminators with no open line.
    queue_item(KIND_REQUEST, 8'hFF);
    queue_item(KIND_CHAR, CHAR_CR);
    queue_item(KIND_CHAR, CHAR_LF);
    // A line led by a null byte is dropped.
    queue_item(KIND_CHAR, 8'h00);
    queue_item(KIND_CHAR, "A");
    queue_item(KIND_CHAR, CHAR_LF);
    // Fill every slot: seven control lines and one data line.
    for (int i = 0; i < 7; i++) begin
      queue_item(KIND_CHAR, command_leads[i]);
      queue_item(KIND_CHAR, (i % 2 == 1) ? CHAR_CR : CHAR_LF);
    end
    queue_item(KIND_CHAR, 8'hFF);
    queue_item(KIND_CHAR, CHAR_CR);
    // No slot left: both a character and a terminator are refused.
    queue_item(KIND_CHAR, "h");
    queue_item(KIND_CHAR, CHAR_LF);
    queue_item(KIND_REQUEST, 8'h00);

    // Two requests release slots, then a line longer than a slot fills one
    // slot to the brim and has its tail dropped.
    queue_request();
    queue_request();
    length = $urandom_range(SLOT_BYTES, SLOT_BYTES + 3);
    queue_item(KIND_CHAR, command_leads[$urandom_range(0, 7)]);
    for (int i = 1; i < length; i++) queue_item(KIND_CHAR, body_byte());
    queue_item(KIND_CHAR, CHAR_CR);
    queue_request();

    // Random part: mostly whole lines with requests, and some noise.
    while (char_items.size() < 150 - (SLOT_COUNT + 1)) begin
      roll = $urandom_range(0, 99);
      if (roll < 73) begin
        length = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        queue_line(length);
        roll = $urandom_range(0, 99);
        if (roll < 60) queue_request();
        if (roll < 15) queue_request();
      end else if (roll < 88) begin
        queue_request();
      end else begin
        queue_item(KIND_CHAR, 8'($urandom_range(0, 255)));
      end
    end
    // Drain whatever lines are still waiting.
    for (int i = 0; i < SLOT_COUNT + 1; i++) queue_request();
    queued_total = char_items.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_total < queued_total || pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d items, %0d of them requests; compared %0d results.",
             queued_total, request_total, results_compared);
    $display("Lines streamed: %0d, empty requests: %0d, refused characters: %0d.",
             lines_streamed, empty_requests, refusals);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Safety limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lswr_pkg.sv
rtl/lswr_front.sv
rtl/lswr_back.sv
rtl/line_slot_window_reader.sv
tb/line_slot_window_reader_checker.sv
tb/line_slot_window_reader_tb.sv
